### rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes carried in the action field
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Value returned by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                     action;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [VAL_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic signed [VAL_W-1:0]  read_value;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/lkvc_req_if.sv
`default_nettype none

interface lkvc_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [lkvc_pkg::KEY_W-1:0]     lookup_key;
  logic signed [lkvc_pkg::VAL_W-1:0]     write_value;

  modport source (output valid, output action, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input action, input lookup_key, input write_value,
                  output ready);
endinterface

`default_nettype wire

### rtl/lkvc_rsp_if.sv
`default_nettype none

interface lkvc_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic signed [lkvc_pkg::VAL_W-1:0]     read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

### rtl/lru_key_value_cache.sv
// Channel   Dir  Payload                              Transfer
// req_i     in   action, lookup_key, write_value      req_i.valid & req_i.ready
// rsp_o     out  found, read_value (gets only)        rsp_o.valid & rsp_o.ready
// cfg       in   cfg_wdata_i = capacity_limit         cfg_we_i
//
// One item at a time. Every request runs a tag scan through the single-port
// read of the slot memory; a put and a get that hits then run the rank update
// sweep through the same port, and a full output register adds its stall.
// Reset is asynchronous and active low; the slot memory is never cleared,
// valid bits gate every slot. A stalled result waits in the output register
// while the next request is already taken.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned Entries = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o
);

  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  lkvc_pkg::req_t             req;
  lkvc_pkg::rsp_t             res, out_q;
  logic                       res_valid, res_ready, out_valid_q;

  // Capacity register: plain write, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign req.action      = req_i.action;
  assign req.lookup_key  = req_i.lookup_key;
  assign req.write_value = req_i.write_value;

  lkvc_core #(
    .Entries (Entries)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (req_i.ready),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: take a new result when empty or when the held one transfers
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_q.found;
  assign rsp_o.read_value = out_q.read_value;

endmodule

`default_nettype wire

### rtl/lkvc_core.sv
`default_nettype none

module lkvc_core #(
  parameter int unsigned Entries = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  lkvc_pkg::req_t             req_i,
  output logic                       req_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0] cap_i,
  output logic                       res_valid_o,
  output lkvc_pkg::rsp_t             res_o,
  input  logic                       res_ready_i
);

  localparam int unsigned IdxW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned StepW = IdxW + 1;
  localparam int unsigned CntW  = $clog2(Entries + 1);
  localparam int unsigned CmpW  = (CntW > lkvc_pkg::CAP_W) ? CntW : lkvc_pkg::CAP_W;
  localparam int unsigned WordW = lkvc_pkg::KEY_W + lkvc_pkg::VAL_W + RankW;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(Entries - 1);
  localparam logic [StepW-1:0] StepEnd = StepW'(Entries);
  localparam logic [CmpW-1:0]  CapMax  = CmpW'(Entries);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]                         state_q, state_d;
  lkvc_pkg::req_t                     req_q;
  logic [StepW-1:0]                   step_q;
  logic                               pipe_vld_q;
  logic [IdxW-1:0]                    pipe_idx_q;
  logic [Entries-1:0]                 valid_q;
  logic [CntW-1:0]                    cnt_q;
  logic                               hit_q, vic_vld_q, free_vld_q, ins_q;
  logic [IdxW-1:0]                    hit_idx_q, vic_idx_q, free_idx_q, tgt_idx_q;
  logic [RankW-1:0]                   hit_rank_q, vic_rank_q;
  logic signed [lkvc_pkg::VAL_W-1:0]  hit_val_q;

  // Key/value/rank memory, one word per slot
  logic [WordW-1:0]                   mem_q [Entries];
  logic [WordW-1:0]                   rd_data_q;
  logic                               mem_we;
  logic [WordW-1:0]                   mem_wdata;

  logic                               rd_go, accept, scan_end, sweep_end, cur_valid, full;
  logic [lkvc_pkg::KEY_W-1:0]         rd_key;
  logic [lkvc_pkg::VAL_W-1:0]         rd_val, upd_val;
  logic [RankW-1:0]                   rd_rank, upd_rank;
  logic [CmpW-1:0]                    cap_ext, eff_cap;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rd_go       = ((state_q == S_SCAN) || (state_q == S_UPD)) && (step_q < StepEnd);
  assign rd_key      = rd_data_q[WordW-1 -: lkvc_pkg::KEY_W];
  assign rd_val      = rd_data_q[RankW +: lkvc_pkg::VAL_W];
  assign rd_rank     = rd_data_q[RankW-1:0];
  assign cur_valid   = valid_q[pipe_idx_q];
  assign scan_end    = (state_q == S_SCAN) && pipe_vld_q && (pipe_idx_q == LastIdx);
  assign sweep_end   = (state_q == S_UPD) && pipe_vld_q && (pipe_idx_q == LastIdx);

  // Effective capacity: zero acts as one, clamp to the slot count
  assign cap_ext = CmpW'(cap_i);
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CapMax) begin
      eff_cap = CapMax;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = CmpW'(cnt_q) >= eff_cap;

  // Write-back word during the update sweep
  always_comb begin
    upd_val  = rd_val;
    upd_rank = rd_rank;
    if (pipe_idx_q == tgt_idx_q) begin
      if (req_q.action == lkvc_pkg::ACT_PUT) begin
        upd_val = req_q.write_value;
      end
      upd_rank = '0;
    end else if (cur_valid && (ins_q || (rd_rank < hit_rank_q))) begin
      upd_rank = rd_rank + RankW'(1);
    end
  end
  assign mem_we    = (state_q == S_UPD) && pipe_vld_q;
  assign mem_wdata = (pipe_idx_q == tgt_idx_q) ? {req_q.lookup_key, upd_val, upd_rank}
                                               : {rd_key, upd_val, upd_rank};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pipe_idx_q] <= mem_wdata;
    end
    rd_data_q <= mem_q[step_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_SCAN;
      S_SCAN: if (scan_end) state_d = S_DEC;
      S_DEC: begin
        if (req_q.action == lkvc_pkg::ACT_GET) begin
          state_d = S_RESP;
        end else begin
          state_d = S_UPD;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = hit_q ? S_UPD : S_IDLE;
        end
      end
      S_UPD: if (sweep_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      pipe_vld_q <= 1'b0;
      valid_q    <= '0;
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      vic_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      ins_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= rd_go;
      if (accept || scan_end) begin
        step_q <= '0;
      end else if (rd_go) begin
        step_q <= step_q + StepW'(1);
      end
      if (accept) begin
        hit_q      <= 1'b0;
        vic_vld_q  <= 1'b0;
        free_vld_q <= 1'b0;
      end else if ((state_q == S_SCAN) && pipe_vld_q) begin
        if (cur_valid && (rd_key == req_q.lookup_key)) hit_q <= 1'b1;
        if (cur_valid && (!vic_vld_q || (rd_rank > vic_rank_q))) vic_vld_q <= 1'b1;
        if (!cur_valid) free_vld_q <= 1'b1;
      end
      // Commit the slot choice; an insert claims the victim or the lowest free slot
      if (state_q == S_DEC) begin
        ins_q <= 1'b0;
        if (!hit_q && (req_q.action == lkvc_pkg::ACT_PUT)) begin
          ins_q <= 1'b1;
          if (full) begin
            valid_q[vic_idx_q] <= 1'b1;
          end else begin
            valid_q[free_idx_q] <= 1'b1;
            cnt_q               <= cnt_q + CntW'(1);
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= step_q[IdxW-1:0];
    if (accept) begin
      req_q <= req_i;
    end
    if ((state_q == S_SCAN) && pipe_vld_q) begin
      if (cur_valid && (rd_key == req_q.lookup_key)) begin
        hit_idx_q  <= pipe_idx_q;
        hit_rank_q <= rd_rank;
        hit_val_q  <= rd_val;
      end
      if (cur_valid && (!vic_vld_q || (rd_rank > vic_rank_q))) begin
        vic_idx_q  <= pipe_idx_q;
        vic_rank_q <= rd_rank;
      end
      if (!cur_valid && !free_vld_q) begin
        free_idx_q <= pipe_idx_q;
      end
    end
    if (state_q == S_DEC) begin
      if (hit_q) begin
        tgt_idx_q <= hit_idx_q;
      end else if (full) begin
        tgt_idx_q <= vic_idx_q;
      end else begin
        tgt_idx_q <= free_idx_q;
      end
    end
  end

  assign res_valid_o      = (state_q == S_RESP);
  assign res_o.found      = hit_q;
  assign res_o.read_value = hit_q ? hit_val_q : lkvc_pkg::MISS_VALUE;

endmodule

`default_nettype wire

### rtl/lkvc_checker.sv
`default_nettype none

module lkvc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              out_found_i,
  input  logic signed [lkvc_pkg::VAL_W-1:0] out_value_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // One item in flight: drop ready right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // A miss always reports the miss value
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_value_i == lkvc_pkg::MISS_VALUE)
    else $error("miss without miss value");

  // A lookup needs a full scan: no result right after a request transfer
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result too early");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_found_i (rsp_o.found),
  .out_value_i (rsp_o.read_value)
);

`default_nettype wire
